// ===== hdl/tbl_pkg.sv =====
`default_nettype none

package tbl_pkg;

	// Shared arithmetic unit widths
	localparam int ACC_W      = 148;	// products up to 146 bits, divide remainder
	localparam int OPB_W      = 104;	// multiplier, numerator or radicand
	localparam int RES_W      = 52;		// quotient or root
	localparam int CNT_W      = 7;
	localparam int DIV_STEPS  = 104;
	localparam int SQRT_STEPS = 52;

	localparam logic [RES_W-1:0] MAG_CAP = 52'h1_0000_0000_0000;

	localparam logic signed [47:0] POS_MAX = 48'sh7FFF_FFFF_FFFF;
	localparam logic signed [47:0] POS_MIN = 48'sh8000_0000_0000;

	localparam logic [47:0] GRAV_RESET = 48'd1231154000;
	localparam logic [31:0] DT_RESET   = 32'd107374182;

	localparam logic [1:0] CFG_GRAV_GAIN = 2'd0;
	localparam logic [1:0] CFG_TIME_STEP = 2'd1;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_STEP = 1'b1;

	typedef enum logic [1:0] {
		MDU_MUL,
		MDU_DIV,
		MDU_SQRT
	} mdu_op_t;

	typedef struct packed {
		logic    start;
		mdu_op_t op;
	} mdu_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} mdu_rsp_t;

	function automatic logic [47:0] mag48(input logic signed [47:0] v);
		logic [47:0] u;
		u = v;
		return u[47] ? (~u + 48'd1) : u;
	endfunction

	// truncated magnitude, sign applied, saturated to 48-bit signed
	function automatic logic signed [47:0] sat_mag(input logic [ACC_W-1:0] m, input logic neg);
		logic [47:0] v;
		v = {1'b0, m[46:0]};
		if (|m[ACC_W-1:47]) return neg ? POS_MIN : POS_MAX;
		return neg ? $signed(~v + 48'd1) : $signed(v);
	endfunction

	function automatic logic signed [47:0] sum_sat(input logic signed [47:0] a,
		input logic signed [47:0] b, input logic signed [47:0] c);
		logic signed [49:0] s;
		s = 50'(a) + 50'(b) + 50'(c);
		if (s > 50'(POS_MAX)) return POS_MAX;
		if (s < 50'(POS_MIN)) return POS_MIN;
		return $signed(s[47:0]);
	endfunction

endpackage

`default_nettype wire

// ===== hdl/tbl_mdu.sv =====
`default_nettype none

// Iterative multiply / divide / square root on one shared add-subtract.
module tbl_mdu (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire tbl_pkg::mdu_req_t              req,
	input  wire logic [tbl_pkg::ACC_W-1:0]      opnd_a,
	input  wire logic [tbl_pkg::OPB_W-1:0]      opnd_b,
	input  wire logic [tbl_pkg::ACC_W-1:0]      opnd_c,
	output tbl_pkg::mdu_rsp_t                   rsp,
	output logic [tbl_pkg::ACC_W-1:0]           prod,
	output logic [tbl_pkg::RES_W-1:0]           quot
);

	tbl_pkg::mdu_op_t              op_q;
	logic                          busy_q;
	logic                          done_q;
	logic [tbl_pkg::CNT_W-1:0]     cnt_q;
	logic [tbl_pkg::ACC_W-1:0]     acc_q;
	logic [tbl_pkg::ACC_W-1:0]     opa_q;
	logic [tbl_pkg::OPB_W-1:0]     opb_q;
	logic [tbl_pkg::RES_W-1:0]     res_q;

	logic [tbl_pkg::ACC_W-1:0]     x;
	logic [tbl_pkg::ACC_W-1:0]     y;
	logic                          sub;
	logic [tbl_pkg::ACC_W:0]       sum;
	logic                          ge;
	logic [tbl_pkg::RES_W-1:0]     qn;

	always_comb begin
		unique case (op_q)
			tbl_pkg::MDU_DIV: begin
				x = {acc_q[tbl_pkg::ACC_W-2:0], opb_q[tbl_pkg::OPB_W-1]};
				y = opa_q;
			end
			tbl_pkg::MDU_SQRT: begin
				x = {acc_q[tbl_pkg::ACC_W-3:0], opb_q[tbl_pkg::OPB_W-1 -: 2]};
				y = tbl_pkg::ACC_W'({res_q, 2'b01});
			end
			default: begin
				x = acc_q;
				y = opb_q[0] ? opa_q : '0;
			end
		endcase
		sub = (op_q != tbl_pkg::MDU_MUL);
		sum = {1'b0, x} + {1'b0, (sub ? ~y : y)} + (tbl_pkg::ACC_W+1)'(sub);
		ge  = sum[tbl_pkg::ACC_W];
		qn  = {res_q[tbl_pkg::RES_W-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q   <= tbl_pkg::MDU_MUL;
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			acc_q  <= '0;
			opa_q  <= '0;
			opb_q  <= '0;
			res_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				op_q   <= req.op;
				busy_q <= 1'b1;
				acc_q  <= (req.op == tbl_pkg::MDU_MUL) ? opnd_c : '0;
				opa_q  <= opnd_a;
				opb_q  <= opnd_b;
				res_q  <= '0;
				cnt_q  <= (req.op == tbl_pkg::MDU_DIV) ? tbl_pkg::CNT_W'(tbl_pkg::DIV_STEPS)
				                                       : tbl_pkg::CNT_W'(tbl_pkg::SQRT_STEPS);
			end else if (busy_q) begin
				unique case (op_q)
					tbl_pkg::MDU_DIV: begin
						acc_q <= ge ? sum[tbl_pkg::ACC_W-1:0] : x;
						res_q <= (qn > tbl_pkg::MAG_CAP) ? tbl_pkg::MAG_CAP : qn;
						opb_q <= opb_q << 1;
						cnt_q <= cnt_q - 1'b1;
						if (cnt_q == tbl_pkg::CNT_W'(1)) begin
							busy_q <= 1'b0;
							done_q <= 1'b1;
						end
					end
					tbl_pkg::MDU_SQRT: begin
						acc_q <= ge ? sum[tbl_pkg::ACC_W-1:0] : x;
						res_q <= qn;
						opb_q <= opb_q << 2;
						cnt_q <= cnt_q - 1'b1;
						if (cnt_q == tbl_pkg::CNT_W'(1)) begin
							busy_q <= 1'b0;
							done_q <= 1'b1;
						end
					end
					default: begin
						// stop as soon as the multiplier runs out of ones
						if (opb_q == '0) begin
							busy_q <= 1'b0;
							done_q <= 1'b1;
						end else begin
							acc_q <= sum[tbl_pkg::ACC_W-1:0];
							opa_q <= opa_q << 1;
							opb_q <= opb_q >> 1;
						end
					end
				endcase
			end
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign prod     = acc_q;
	assign quot     = res_q;

endmodule

`default_nettype wire

// ===== hdl/two_body_leapfrog_step.sv =====
`default_nettype none

// Two-body gravity integrator, velocity Verlet, signed Q24.24 state.
// Item channel (item_valid / item_stall): opcode load writes one body's
// position and velocity and recomputes both accelerations; opcode step
// advances the system by one time step (body one first, body two against
// body one's new position). Every item yields one request on the result
// channel (result_valid / result_stall) with both positions and the
// zero-distance flag. One item is in flight at a time.
// Config channel (cfg_valid / cfg_ready, always ready): index 0 grav_gain,
// index 1 time_step; other indexes are dropped. Write only while idle.
// Every product, root and quotient runs on one shared iterative unit, so
// the sequencer waits for each one in turn. A load runs the acceleration
// update for both bodies; a step also runs both bodies' position and
// velocity updates.
// item_stall is high from acceptance until the result is moved into the
// output register; a result held by result_stall blocks only the next
// item's final hand-off. Reset clears all body state, restores the
// register defaults and empties the output register.
module two_body_leapfrog_step (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               item_valid,
	output logic                    item_stall,
	input  wire logic               opcode,
	input  wire logic               body_select,
	input  wire logic signed [47:0] load_pos_x,
	input  wire logic signed [47:0] load_pos_y,
	input  wire logic signed [47:0] load_vel_x,
	input  wire logic signed [47:0] load_vel_y,
	output logic                    result_valid,
	input  wire logic               result_stall,
	output logic signed [47:0]      first_pos_x,
	output logic signed [47:0]      first_pos_y,
	output logic signed [47:0]      second_pos_x,
	output logic signed [47:0]      second_pos_y,
	output logic                    zero_distance,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [47:0]        cfg_data
);

	typedef enum logic [4:0] {
		ST_IDLE, ST_DT2,
		ST_DVX, ST_DAX, ST_DVY, ST_DAY,
		ST_K1X, ST_K1Y,
		ST_ADIFF, ST_AXX, ST_AYY, ST_SQRT, ST_DEN,
		ST_NUMX, ST_DIVX, ST_NUMY, ST_DIVY,
		ST_K2X, ST_K2Y,
		ST_OUT
	} state_t;

	state_t                  state_q;
	logic                    me_q;
	logic                    step_q;
	logic                    go_q;
	logic                    zf_q;

	logic signed [47:0]      pos_x_q [2];
	logic signed [47:0]      pos_y_q [2];
	logic signed [47:0]      vel_x_q [2];
	logic signed [47:0]      vel_y_q [2];
	logic signed [47:0]      acc_x_q [2];
	logic signed [47:0]      acc_y_q [2];

	logic [47:0]             grav_q;
	logic [31:0]             dt_q;
	logic [63:0]             dt2_q;
	logic signed [47:0]      term_q;
	logic [48:0]             dx_q;
	logic [48:0]             dy_q;
	logic [97:0]             d2_q;
	logic [tbl_pkg::RES_W-1:0] s_q;
	logic [tbl_pkg::ACC_W-1:0] den_q;
	logic [tbl_pkg::OPB_W-1:0] num_q;

	logic                    res_valid_q;
	logic signed [47:0]      out_p0x_q;
	logic signed [47:0]      out_p0y_q;
	logic signed [47:0]      out_p1x_q;
	logic signed [47:0]      out_p1y_q;
	logic                    out_zf_q;

	tbl_pkg::mdu_req_t       mdu_req;
	tbl_pkg::mdu_rsp_t       mdu_rsp;
	logic [tbl_pkg::ACC_W-1:0] opnd_a;
	logic [tbl_pkg::OPB_W-1:0] opnd_b;
	logic [tbl_pkg::ACC_W-1:0] opnd_c;
	logic [tbl_pkg::ACC_W-1:0] prod;
	logic [tbl_pkg::RES_W-1:0] quot;

	logic                    oth;
	logic [48:0]             ux;
	logic [48:0]             uy;
	logic [47:0]             m_vx;
	logic [47:0]             m_vy;
	logic [47:0]             m_ax;
	logic [47:0]             m_ay;
	logic                    same_pos;

	assign oth  = ~me_q;
	assign ux   = dx_q[48] ? (~dx_q + 49'd1) : dx_q;
	assign uy   = dy_q[48] ? (~dy_q + 49'd1) : dy_q;
	assign m_vx = tbl_pkg::mag48(vel_x_q[me_q]);
	assign m_vy = tbl_pkg::mag48(vel_y_q[me_q]);
	assign m_ax = tbl_pkg::mag48(acc_x_q[me_q]);
	assign m_ay = tbl_pkg::mag48(acc_y_q[me_q]);
	assign same_pos = (pos_x_q[oth] == pos_x_q[me_q]) && (pos_y_q[oth] == pos_y_q[me_q]);

	// Operand select for the shared unit, by sequencer step
	always_comb begin
		opnd_a        = '0;
		opnd_b        = '0;
		opnd_c        = '0;
		mdu_req.start = go_q;
		mdu_req.op    = tbl_pkg::MDU_MUL;
		unique case (state_q)
			ST_DT2: begin
				opnd_a = tbl_pkg::ACC_W'(dt_q);
				opnd_b = tbl_pkg::OPB_W'(dt_q);
			end
			ST_DVX: begin
				opnd_a = tbl_pkg::ACC_W'(m_vx);
				opnd_b = tbl_pkg::OPB_W'(dt_q);
			end
			ST_DVY: begin
				opnd_a = tbl_pkg::ACC_W'(m_vy);
				opnd_b = tbl_pkg::OPB_W'(dt_q);
			end
			ST_DAX: begin
				opnd_a = tbl_pkg::ACC_W'(m_ax);
				opnd_b = tbl_pkg::OPB_W'(dt2_q);
			end
			ST_DAY: begin
				opnd_a = tbl_pkg::ACC_W'(m_ay);
				opnd_b = tbl_pkg::OPB_W'(dt2_q);
			end
			ST_K1X, ST_K2X: begin
				opnd_a = tbl_pkg::ACC_W'(m_ax);
				opnd_b = tbl_pkg::OPB_W'(dt_q);
			end
			ST_K1Y, ST_K2Y: begin
				opnd_a = tbl_pkg::ACC_W'(m_ay);
				opnd_b = tbl_pkg::OPB_W'(dt_q);
			end
			ST_AXX: begin
				opnd_a = tbl_pkg::ACC_W'(ux);
				opnd_b = tbl_pkg::OPB_W'(ux);
			end
			ST_AYY: begin
				// accumulate on top of dx squared
				opnd_a = tbl_pkg::ACC_W'(uy);
				opnd_b = tbl_pkg::OPB_W'(uy);
				opnd_c = tbl_pkg::ACC_W'(d2_q);
			end
			ST_SQRT: begin
				opnd_b     = tbl_pkg::OPB_W'(d2_q);
				mdu_req.op = tbl_pkg::MDU_SQRT;
			end
			ST_DEN: begin
				opnd_a = tbl_pkg::ACC_W'(d2_q);
				opnd_b = tbl_pkg::OPB_W'(s_q);
			end
			ST_NUMX: begin
				opnd_a = tbl_pkg::ACC_W'({ux, 8'd0});
				opnd_b = tbl_pkg::OPB_W'(grav_q);
			end
			ST_NUMY: begin
				opnd_a = tbl_pkg::ACC_W'({uy, 8'd0});
				opnd_b = tbl_pkg::OPB_W'(grav_q);
			end
			ST_DIVX, ST_DIVY: begin
				opnd_a     = den_q;
				opnd_b     = num_q;
				mdu_req.op = tbl_pkg::MDU_DIV;
			end
			default: begin
				opnd_a = '0;
			end
		endcase
	end

	tbl_mdu u_mdu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mdu_req),
		.opnd_a (opnd_a),
		.opnd_b (opnd_b),
		.opnd_c (opnd_c),
		.rsp    (mdu_rsp),
		.prod   (prod),
		.quot   (quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			me_q        <= 1'b0;
			step_q      <= 1'b0;
			go_q        <= 1'b0;
			zf_q        <= 1'b0;
			for (int i = 0; i < 2; i++) begin
				pos_x_q[i] <= '0;
				pos_y_q[i] <= '0;
				vel_x_q[i] <= '0;
				vel_y_q[i] <= '0;
				acc_x_q[i] <= '0;
				acc_y_q[i] <= '0;
			end
			grav_q      <= tbl_pkg::GRAV_RESET;
			dt_q        <= tbl_pkg::DT_RESET;
			dt2_q       <= '0;
			term_q      <= '0;
			dx_q        <= '0;
			dy_q        <= '0;
			d2_q        <= '0;
			s_q         <= '0;
			den_q       <= '0;
			num_q       <= '0;
			res_valid_q <= 1'b0;
			out_p0x_q   <= '0;
			out_p0y_q   <= '0;
			out_p1x_q   <= '0;
			out_p1y_q   <= '0;
			out_zf_q    <= 1'b0;
		end else begin
			go_q <= 1'b0;

			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					tbl_pkg::CFG_GRAV_GAIN: begin
						grav_q <= cfg_data;
					end
					tbl_pkg::CFG_TIME_STEP: begin
						dt_q <= cfg_data[31:0];
					end
					default: begin
					end
				endcase
			end

			// release the result once taken; the output step refills it itself
			if (res_valid_q && !result_stall && (state_q != ST_OUT)) begin
				res_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						me_q <= 1'b0;
						zf_q <= 1'b0;
						if (opcode == tbl_pkg::OP_LOAD) begin
							pos_x_q[body_select] <= load_pos_x;
							pos_y_q[body_select] <= load_pos_y;
							vel_x_q[body_select] <= load_vel_x;
							vel_y_q[body_select] <= load_vel_y;
							step_q  <= 1'b0;
							state_q <= ST_ADIFF;
						end else begin
							step_q  <= 1'b1;
							state_q <= ST_DT2;
							go_q    <= 1'b1;
						end
					end
				end
				ST_DT2: begin
					if (mdu_rsp.done) begin
						dt2_q   <= prod[63:0];
						state_q <= ST_DVX;
						go_q    <= 1'b1;
					end
				end
				ST_DVX: begin
					if (mdu_rsp.done) begin
						term_q  <= tbl_pkg::sat_mag(prod >> 32, vel_x_q[me_q][47]);
						state_q <= ST_DAX;
						go_q    <= 1'b1;
					end
				end
				ST_DAX: begin
					if (mdu_rsp.done) begin
						pos_x_q[me_q] <= tbl_pkg::sum_sat(pos_x_q[me_q], term_q,
							tbl_pkg::sat_mag(prod >> 65, acc_x_q[me_q][47]));
						state_q <= ST_DVY;
						go_q    <= 1'b1;
					end
				end
				ST_DVY: begin
					if (mdu_rsp.done) begin
						term_q  <= tbl_pkg::sat_mag(prod >> 32, vel_y_q[me_q][47]);
						state_q <= ST_DAY;
						go_q    <= 1'b1;
					end
				end
				ST_DAY: begin
					if (mdu_rsp.done) begin
						pos_y_q[me_q] <= tbl_pkg::sum_sat(pos_y_q[me_q], term_q,
							tbl_pkg::sat_mag(prod >> 65, acc_y_q[me_q][47]));
						state_q <= ST_K1X;
						go_q    <= 1'b1;
					end
				end
				ST_K1X: begin
					if (mdu_rsp.done) begin
						vel_x_q[me_q] <= tbl_pkg::sum_sat(vel_x_q[me_q],
							tbl_pkg::sat_mag(prod >> 33, acc_x_q[me_q][47]), 48'sd0);
						state_q <= ST_K1Y;
						go_q    <= 1'b1;
					end
				end
				ST_K1Y: begin
					if (mdu_rsp.done) begin
						vel_y_q[me_q] <= tbl_pkg::sum_sat(vel_y_q[me_q],
							tbl_pkg::sat_mag(prod >> 33, acc_y_q[me_q][47]), 48'sd0);
						state_q <= ST_ADIFF;
					end
				end
				ST_ADIFF: begin
					dx_q <= {pos_x_q[oth][47], pos_x_q[oth]} - {pos_x_q[me_q][47], pos_x_q[me_q]};
					dy_q <= {pos_y_q[oth][47], pos_y_q[oth]} - {pos_y_q[me_q][47], pos_y_q[me_q]};
					if (same_pos) begin
						// bodies coincide: hold acceleration at zero and flag it
						acc_x_q[me_q] <= '0;
						acc_y_q[me_q] <= '0;
						zf_q          <= 1'b1;
						if (step_q) begin
							state_q <= ST_K2X;
							go_q    <= 1'b1;
						end else if (!me_q) begin
							me_q    <= 1'b1;
							state_q <= ST_ADIFF;
						end else begin
							state_q <= ST_OUT;
						end
					end else begin
						state_q <= ST_AXX;
						go_q    <= 1'b1;
					end
				end
				ST_AXX: begin
					if (mdu_rsp.done) begin
						d2_q    <= prod[97:0];
						state_q <= ST_AYY;
						go_q    <= 1'b1;
					end
				end
				ST_AYY: begin
					if (mdu_rsp.done) begin
						d2_q    <= prod[97:0];
						state_q <= ST_SQRT;
						go_q    <= 1'b1;
					end
				end
				ST_SQRT: begin
					if (mdu_rsp.done) begin
						s_q     <= quot;
						state_q <= ST_DEN;
						go_q    <= 1'b1;
					end
				end
				ST_DEN: begin
					if (mdu_rsp.done) begin
						den_q   <= prod;
						state_q <= ST_NUMX;
						go_q    <= 1'b1;
					end
				end
				ST_NUMX: begin
					if (mdu_rsp.done) begin
						num_q   <= prod[tbl_pkg::OPB_W-1:0];
						state_q <= ST_DIVX;
						go_q    <= 1'b1;
					end
				end
				ST_DIVX: begin
					if (mdu_rsp.done) begin
						acc_x_q[me_q] <= tbl_pkg::sat_mag(tbl_pkg::ACC_W'(quot), dx_q[48]);
						state_q <= ST_NUMY;
						go_q    <= 1'b1;
					end
				end
				ST_NUMY: begin
					if (mdu_rsp.done) begin
						num_q   <= prod[tbl_pkg::OPB_W-1:0];
						state_q <= ST_DIVY;
						go_q    <= 1'b1;
					end
				end
				ST_DIVY: begin
					if (mdu_rsp.done) begin
						acc_y_q[me_q] <= tbl_pkg::sat_mag(tbl_pkg::ACC_W'(quot), dy_q[48]);
						if (step_q) begin
							state_q <= ST_K2X;
							go_q    <= 1'b1;
						end else if (!me_q) begin
							me_q    <= 1'b1;
							state_q <= ST_ADIFF;
						end else begin
							state_q <= ST_OUT;
						end
					end
				end
				ST_K2X: begin
					if (mdu_rsp.done) begin
						vel_x_q[me_q] <= tbl_pkg::sum_sat(vel_x_q[me_q],
							tbl_pkg::sat_mag(prod >> 33, acc_x_q[me_q][47]), 48'sd0);
						state_q <= ST_K2Y;
						go_q    <= 1'b1;
					end
				end
				ST_K2Y: begin
					if (mdu_rsp.done) begin
						vel_y_q[me_q] <= tbl_pkg::sum_sat(vel_y_q[me_q],
							tbl_pkg::sat_mag(prod >> 33, acc_y_q[me_q][47]), 48'sd0);
						if (!me_q) begin
							// second body moves against the first body's new position
							me_q    <= 1'b1;
							state_q <= ST_DVX;
							go_q    <= 1'b1;
						end else begin
							state_q <= ST_OUT;
						end
					end
				end
				ST_OUT: begin
					// wait here only while the previous result is still held
					if (!res_valid_q || !result_stall) begin
						out_p0x_q   <= pos_x_q[0];
						out_p0y_q   <= pos_y_q[0];
						out_p1x_q   <= pos_x_q[1];
						out_p1y_q   <= pos_y_q[1];
						out_zf_q    <= zf_q;
						res_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign item_stall    = (state_q != ST_IDLE);
	assign cfg_ready     = 1'b1;
	assign result_valid  = res_valid_q;
	assign first_pos_x   = out_p0x_q;
	assign first_pos_y   = out_p0y_q;
	assign second_pos_x  = out_p1x_q;
	assign second_pos_y  = out_p1y_q;
	assign zero_distance = out_zf_q;

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> state_q != ST_IDLE)
		else $error("accepted item did not start the sequencer");

	a_done_in_unit_step: assert property (@(posedge clk) disable iff (!arst_n)
		mdu_rsp.done |-> (state_q != ST_IDLE) && (state_q != ST_ADIFF) && (state_q != ST_OUT))
		else $error("arithmetic unit finished outside a step that uses it");

	a_start_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		mdu_req.start |-> !mdu_rsp.busy)
		else $error("arithmetic unit started while busy");

	a_result_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(state_q == ST_OUT))
		else $error("result raised outside the output step");

endmodule

`default_nettype wire
